// File: rtl/apr_pkg.sv
// ----------------------------------------------------------------------------
// Aging page replacement package
// Shared constants, controller states and the small control structs that
// travel between the controller and the frame cells.
// ----------------------------------------------------------------------------
package apr_pkg;

  // Default sizes of the frame table.
  localparam int APR_FRAMES_DEFAULT       = 16;
  localparam int APR_AGE_BITS_DEFAULT     = 8;
  localparam int APR_PAGE_ID_BITS_DEFAULT = 16;

  // Fixed field widths of the ports.
  localparam int APR_CFG_BITS   = 5;
  localparam int APR_FRAME_BITS = 4;
  localparam int APR_COUNT_BITS = 32;

  typedef logic [APR_CFG_BITS-1:0]   apr_cfg_t;
  typedef logic [APR_FRAME_BITS-1:0] apr_frame_t;
  typedef logic [APR_COUNT_BITS-1:0] apr_count_t;

  // Number of frames in use after reset.
  localparam apr_cfg_t APR_FRAMES_RESET = apr_cfg_t'(16);

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } apr_state_t;

  // Flags carried by the scan token from cell to cell.
  typedef struct packed {
    logic found;
    logic has_empty;
  } apr_flags_t;

  // Update command broadcast to every cell at the end of a scan.
  typedef struct packed {
    logic en;
    logic miss;
  } apr_upd_t;

endpackage

// File: rtl/apr_channels.sv
// ----------------------------------------------------------------------------
// Aging page replacement channels
// Valid/ready interfaces for page references, results and the frame count
// configuration register.
// ----------------------------------------------------------------------------

// Page reference channel.
interface apr_page_if #(
  parameter int PAGE_ID_BITS = 16
);
  logic                    valid;
  logic                    ready;
  logic [PAGE_ID_BITS-1:0] page_id;

  modport source (output valid, output page_id, input ready);
  modport sink   (input valid, input page_id, output ready);
endinterface

// Result channel.
interface apr_result_if #(
  parameter int PAGE_ID_BITS = 16
);
  import apr_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    hit;
  apr_frame_t              frame;
  logic                    replaced;
  logic [PAGE_ID_BITS-1:0] evicted_page;
  apr_count_t              hit_count;
  apr_count_t              miss_count;

  modport source (output valid, output hit, output frame, output replaced,
                  output evicted_page, output hit_count, output miss_count,
                  input ready);
  modport sink   (input valid, input hit, input frame, input replaced,
                  input evicted_page, input hit_count, input miss_count,
                  output ready);
endinterface

// Configuration write channel.
interface apr_cfg_if;
  import apr_pkg::*;

  logic     valid;
  logic     ready;
  apr_cfg_t frames_in_use;

  modport source (output valid, output frames_in_use, input ready);
  modport sink   (input valid, input frames_in_use, output ready);
endinterface

// File: rtl/apr_cell.sv
// ----------------------------------------------------------------------------
// Aging page replacement frame cell
// Holds one frame's page id and aging counter. A scan token passes through
// the cell's token register, picking up a match, the first empty frame and the
// smallest counter seen so far.
// ----------------------------------------------------------------------------
module apr_cell #(
  parameter int INDEX        = 0,
  parameter int IDXW         = 4,
  parameter int AGE_BITS     = 8,
  parameter int PAGE_ID_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_use,
  input  logic [PAGE_ID_BITS-1:0] pid,
  input  apr_pkg::apr_upd_t       upd,
  input  logic [IDXW-1:0]         slot,
  // Token from the previous cell.
  input  apr_pkg::apr_flags_t     flags_in,
  input  logic [IDXW-1:0]         hit_idx_in,
  input  logic [IDXW-1:0]         empty_idx_in,
  input  logic [AGE_BITS-1:0]     min_age_in,
  input  logic [IDXW-1:0]         min_idx_in,
  input  logic [PAGE_ID_BITS-1:0] min_page_in,
  // Token to the next cell.
  output apr_pkg::apr_flags_t     flags_out,
  output logic [IDXW-1:0]         hit_idx_out,
  output logic [IDXW-1:0]         empty_idx_out,
  output logic [AGE_BITS-1:0]     min_age_out,
  output logic [IDXW-1:0]         min_idx_out,
  output logic [PAGE_ID_BITS-1:0] min_page_out
);
  import apr_pkg::*;

  localparam logic [IDXW-1:0] MY_IDX = IDXW'(INDEX);

  logic [PAGE_ID_BITS-1:0] page;
  logic [AGE_BITS-1:0]     age;

  apr_flags_t              flags_next;
  logic [IDXW-1:0]         hit_idx_next;
  logic [IDXW-1:0]         empty_idx_next;
  logic [AGE_BITS-1:0]     min_age_next;
  logic [IDXW-1:0]         min_idx_next;
  logic [PAGE_ID_BITS-1:0] min_page_next;

  // Fold this frame into the token. The first cell always takes the minimum.
  always_comb begin
    flags_next     = flags_in;
    hit_idx_next   = hit_idx_in;
    empty_idx_next = empty_idx_in;
    min_age_next   = min_age_in;
    min_idx_next   = min_idx_in;
    min_page_next  = min_page_in;
    if (in_use) begin
      if (!flags_in.found && page == pid) begin
        flags_next.found = 1'b1;
        hit_idx_next     = MY_IDX;
      end
      if (!flags_in.has_empty && page == '0) begin
        flags_next.has_empty = 1'b1;
        empty_idx_next       = MY_IDX;
      end
      if (INDEX == 0 || age < min_age_in) begin
        min_age_next  = age;
        min_idx_next  = MY_IDX;
        min_page_next = page;
      end
    end
  end

  // Token register towards the next cell.
  always_ff @(posedge clk) begin
    flags_out     <= flags_next;
    hit_idx_out   <= hit_idx_next;
    empty_idx_out <= empty_idx_next;
    min_age_out   <= min_age_next;
    min_idx_out   <= min_idx_next;
    min_page_out  <= min_page_next;
  end

  // Frame contents: age every frame in use, mark the referenced one.
  always_ff @(posedge clk) begin
    if (rst) begin
      page <= '0;
      age  <= '0;
    end else if (upd.en && in_use) begin
      if (slot == MY_IDX) begin
        if (upd.miss) begin
          page <= pid;
          age  <= {1'b1, {(AGE_BITS-1){1'b0}}};
        end else begin
          age  <= {1'b1, age[AGE_BITS-1:1]};
        end
      end else begin
        age <= {1'b0, age[AGE_BITS-1:1]};
      end
    end
  end

endmodule

// File: rtl/aging_page_replacement.sv
// ----------------------------------------------------------------------------
// Aging page replacement unit
// A new reference is taken only while idle, so one item is in flight at a
// time. The scan token walks the chain of frame cells, one cell per cycle,
// and the result is registered in the update state, which waits while the
// previous result is still held by the receiver.
// Reset: all frames empty, counters and hit/miss counts zero, 16 frames in use.
// ----------------------------------------------------------------------------
module aging_page_replacement #(
  parameter int FRAMES       = apr_pkg::APR_FRAMES_DEFAULT,
  parameter int AGE_BITS     = apr_pkg::APR_AGE_BITS_DEFAULT,
  parameter int PAGE_ID_BITS = apr_pkg::APR_PAGE_ID_BITS_DEFAULT
) (
  input  logic   clk,
  input  logic   rst,
  apr_cfg_if.sink       cfg,
  apr_page_if.sink      request,
  apr_result_if.source  result
);
  import apr_pkg::*;

  localparam int IDXW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(FRAMES - 1);

  apr_state_t state, state_next;
  logic [IDXW-1:0]         cnt;
  logic [PAGE_ID_BITS-1:0] pid_reg;
  apr_cfg_t                frames_cfg;

  logic                    out_valid;
  logic                    out_hit;
  apr_frame_t              out_frame;
  logic                    out_replaced;
  logic [PAGE_ID_BITS-1:0] out_evicted;
  apr_count_t              hit_count;
  apr_count_t              miss_count;

  logic [FRAMES-1:0]       in_use;
  apr_upd_t                upd;
  logic                    done_ok;
  logic                    pid_zero;

  // Scan token chain, entry 0 is the empty token fed into the first cell.
  apr_flags_t              tok_flags    [FRAMES+1];
  logic [IDXW-1:0]         tok_hit_idx  [FRAMES+1];
  logic [IDXW-1:0]         tok_empty_idx[FRAMES+1];
  logic [AGE_BITS-1:0]     tok_min_age  [FRAMES+1];
  logic [IDXW-1:0]         tok_min_idx  [FRAMES+1];
  logic [PAGE_ID_BITS-1:0] tok_min_page [FRAMES+1];

  // Outcome of the finished scan.
  logic                    res_hit;
  logic                    res_repl;
  logic [IDXW-1:0]         res_slot;
  logic [PAGE_ID_BITS-1:0] res_evicted;

  assign tok_flags[0]     = '0;
  assign tok_hit_idx[0]   = '0;
  assign tok_empty_idx[0] = '0;
  assign tok_min_age[0]   = '1;
  assign tok_min_idx[0]   = '0;
  assign tok_min_page[0]  = '0;

  // Frame cells. A count of zero acts as one; above FRAMES, every cell is in use.
  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    assign in_use[g] = (g == 0) || (32'(g) < 32'(frames_cfg));

    apr_cell #(
      .INDEX        (g),
      .IDXW         (IDXW),
      .AGE_BITS     (AGE_BITS),
      .PAGE_ID_BITS (PAGE_ID_BITS)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .in_use        (in_use[g]),
      .pid           (pid_reg),
      .upd           (upd),
      .slot          (res_slot),
      .flags_in      (tok_flags[g]),
      .hit_idx_in    (tok_hit_idx[g]),
      .empty_idx_in  (tok_empty_idx[g]),
      .min_age_in    (tok_min_age[g]),
      .min_idx_in    (tok_min_idx[g]),
      .min_page_in   (tok_min_page[g]),
      .flags_out     (tok_flags[g+1]),
      .hit_idx_out   (tok_hit_idx[g+1]),
      .empty_idx_out (tok_empty_idx[g+1]),
      .min_age_out   (tok_min_age[g+1]),
      .min_idx_out   (tok_min_idx[g+1]),
      .min_page_out  (tok_min_page[g+1])
    );
  end

  // Decision from the token that left the last cell.
  always_comb begin
    res_hit     = tok_flags[FRAMES].found;
    res_repl    = !tok_flags[FRAMES].found && !tok_flags[FRAMES].has_empty;
    res_evicted = res_repl ? tok_min_page[FRAMES] : '0;
    if (tok_flags[FRAMES].found) begin
      res_slot = tok_hit_idx[FRAMES];
    end else if (tok_flags[FRAMES].has_empty) begin
      res_slot = tok_empty_idx[FRAMES];
    end else begin
      res_slot = tok_min_idx[FRAMES];
    end
  end

  assign pid_zero = (pid_reg == '0);
  assign done_ok  = !out_valid || result.ready;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (request.valid) state_next = ST_SCAN;
      ST_SCAN:   if (cnt == LAST_IDX) state_next = ST_UPDATE;
      ST_UPDATE: if (done_ok) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Controller outputs.
  always_comb begin
    request.ready = 1'b0;
    upd           = '0;
    unique case (state)
      ST_IDLE: request.ready = 1'b1;
      ST_UPDATE: begin
        upd.en   = done_ok && !pid_zero;
        upd.miss = !res_hit;
      end
      default: ;
    endcase
  end

  // State, scan counter and reference register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE) begin
        cnt <= '0;
      end else if (state == ST_SCAN) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (request.valid && request.ready) begin
      pid_reg <= request.page_id;
    end
  end

  // Configuration register.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_cfg <= APR_FRAMES_RESET;
    end else if (cfg.valid) begin
      frames_cfg <= cfg.frames_in_use;
    end
  end

  // Result register and saturating counts.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      hit_count  <= '0;
      miss_count <= '0;
    end else if (state == ST_UPDATE && done_ok) begin
      out_valid <= 1'b1;
      if (!pid_zero) begin
        if (res_hit && hit_count != '1) begin
          hit_count <= hit_count + 1'b1;
        end
        if (!res_hit && miss_count != '1) begin
          miss_count <= miss_count + 1'b1;
        end
      end
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_UPDATE && done_ok) begin
      if (pid_zero) begin
        out_hit      <= 1'b0;
        out_frame    <= '0;
        out_replaced <= 1'b0;
        out_evicted  <= '0;
      end else begin
        out_hit      <= res_hit;
        out_frame    <= apr_frame_t'(res_slot);
        out_replaced <= res_repl;
        out_evicted  <= res_evicted;
      end
    end
  end

  assign result.valid        = out_valid;
  assign result.hit          = out_hit;
  assign result.frame        = out_frame;
  assign result.replaced     = out_replaced;
  assign result.evicted_page = out_evicted;
  assign result.hit_count    = hit_count;
  assign result.miss_count   = miss_count;

endmodule

// File: tb/tb_aging_page_replacement.sv
// ----------------------------------------------------------------------------
// Aging page replacement testbench
// Drives page references and frame count writes into the unit and predicts
// every result with its own model of the frame table and aging counters.
// Each accepted result is checked field by field against the oldest
// prediction. A directed opening covers the edge cases, and random phases
// with shifting working sets and frame counts follow it.
// ----------------------------------------------------------------------------
module tb_aging_page_replacement;
  timeunit 1ns;
  timeprecision 1ps;

  import apr_pkg::*;

  localparam int FRAMES       = APR_FRAMES_DEFAULT;
  localparam int AGE_W        = APR_AGE_BITS_DEFAULT;
  localparam int PID_W        = APR_PAGE_ID_BITS_DEFAULT;
  localparam int LATENCY      = FRAMES + 2;
  localparam int RANDOM_ITEMS = 1400;
  localparam int CALM_ITEMS   = 150;

  // Kinds of entry in the stimulus queue.
  typedef enum logic [1:0] {
    ENT_PAGE,
    ENT_CFG,
    ENT_DRAIN
  } entry_kind_t;

  typedef struct {
    entry_kind_t      kind;
    logic [PID_W-1:0] value;
    int               gap;
    bit               calm;
  } stim_entry_t;

  typedef struct packed {
    logic             hit;
    apr_frame_t       frame;
    logic             replaced;
    logic [PID_W-1:0] evicted_page;
    apr_count_t       hit_count;
    apr_count_t       miss_count;
  } lookup_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  apr_cfg_if                           cfg_ch ();
  apr_page_if   #(.PAGE_ID_BITS(PID_W)) req_ch ();
  apr_result_if #(.PAGE_ID_BITS(PID_W)) res_ch ();

  aging_page_replacement #(
    .FRAMES      (FRAMES),
    .AGE_BITS    (AGE_W),
    .PAGE_ID_BITS(PID_W)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .request(req_ch),
    .result (res_ch)
  );

  // Clock with a 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Stimulus, predictions and bookkeeping.
  stim_entry_t    stim_q[$];
  lookup_result_t expected_q[$];
  int             pending_n   = 0;
  int             mismatch_n  = 0;
  int             gap_left    = 0;
  int             stall_left  = 0;
  int             cyc_n       = 0;
  bit             rx_calm     = 1'b0;

  // Predicted state of the unit.
  logic [PID_W-1:0] frame_tbl [FRAMES];
  logic [AGE_W-1:0] age_tbl   [FRAMES];
  apr_count_t       hits_seen;
  apr_count_t       misses_seen;
  apr_cfg_t         frames_cfg;

  // Every input is known from time zero.
  initial begin
    req_ch.valid         = 1'b0;
    req_ch.page_id       = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.frames_in_use = '0;
    res_ch.ready         = 1'b0;
  end

  task automatic add_ref(input logic [PID_W-1:0] pid, input int gap = 0,
                         input bit calm = 1'b0);
    stim_q.push_back('{ENT_PAGE, pid, gap, calm});
  endtask

  task automatic add_cfg(input int count);
    stim_q.push_back('{ENT_CFG, PID_W'(count), 0, 1'b0});
  endtask

  task automatic add_drain();
    stim_q.push_back('{ENT_DRAIN, '0, 0, 1'b0});
  endtask

  // Looks a page up in the predicted frame table, replaces and ages frames.
  task automatic lookup_page(input logic [PID_W-1:0] pid,
                             output lookup_result_t res);
    int n;
    int slot;
    int best;
    bit found;
    bit empty;
    n     = int'(frames_cfg);
    slot  = 0;
    best  = 0;
    found = 1'b0;
    empty = 1'b0;
    res   = '0;
    if (n == 0) n = 1;
    if (n > FRAMES) n = FRAMES;
    if (pid != '0) begin
      for (int i = 0; i < n; i++) begin
        if (!found && frame_tbl[i] == pid) begin
          slot  = i;
          found = 1'b1;
        end
      end
      if (found) begin
        if (hits_seen != '1) hits_seen++;
      end else begin
        if (misses_seen != '1) misses_seen++;
        for (int i = 0; i < n; i++) begin
          if (!empty && frame_tbl[i] == '0) begin
            slot  = i;
            empty = 1'b1;
          end
        end
        // No free frame: evict the one with the smallest counter.
        if (!empty) begin
          for (int i = 1; i < n; i++) begin
            if (age_tbl[i] < age_tbl[best]) best = i;
          end
          slot             = best;
          res.replaced     = 1'b1;
          res.evicted_page = frame_tbl[slot];
        end
        frame_tbl[slot] = pid;
        age_tbl[slot]   = '0;
      end
      for (int i = 0; i < n; i++) age_tbl[i] = age_tbl[i] >> 1;
      age_tbl[slot][AGE_W-1] = 1'b1;
      res.hit   = found;
      res.frame = apr_frame_t'(slot);
    end
    res.hit_count  = hits_seen;
    res.miss_count = misses_seen;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_n++;
    end
  endtask

  // Driver: feeds references and writes from the queue, and paces ready.
  always @(posedge clk) begin : drive_channels
    stim_entry_t head;
    bit          launch_req;
    bit          launch_cfg;
    bit          idle_now;
    launch_req = 1'b0;
    launch_cfg = 1'b0;
    if (rst) begin
      req_ch.valid <= 1'b0;
      cfg_ch.valid <= 1'b0;
      res_ch.ready <= 1'b0;
    end else begin
      cyc_n++;
      idle_now = !req_ch.valid && !cfg_ch.valid && pending_n == 0;
      // A stalled item is held as it is.
      if (!((req_ch.valid && !req_ch.ready) || (cfg_ch.valid && !cfg_ch.ready))) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (stim_q.size() != 0) begin
          head = stim_q[0];
          case (head.kind)
            ENT_PAGE: begin
              if (head.gap != 0) begin
                gap_left      = head.gap - 1;
                stim_q[0].gap = 0;
              end else begin
                void'(stim_q.pop_front());
                req_ch.page_id <= head.value;
                launch_req = 1'b1;
                rx_calm    = head.calm;
              end
            end
            ENT_CFG: begin
              if (idle_now) begin
                void'(stim_q.pop_front());
                cfg_ch.frames_in_use <= apr_cfg_t'(head.value);
                launch_cfg = 1'b1;
              end
            end
            default: begin
              if (idle_now) void'(stim_q.pop_front());
            end
          endcase
        end
        req_ch.valid <= launch_req;
        cfg_ch.valid <= launch_cfg;
      end
      // Receiver stalls in bursts, only in alternate stretches of the run.
      if (stall_left != 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else if (!rx_calm && ((cyc_n / 400) % 2 == 0) && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 16) - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Monitor: checks results, then tracks writes and predicts new items.
  always @(posedge clk) begin : watch_channels
    lookup_result_t want;
    if (rst) begin
      for (int i = 0; i < FRAMES; i++) begin
        frame_tbl[i] = '0;
        age_tbl[i]   = '0;
      end
      hits_seen   = '0;
      misses_seen = '0;
      frames_cfg  = APR_FRAMES_RESET;
      pending_n <= 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_q.size() == 0) begin
          $error("result item arrived with no reference outstanding");
          mismatch_n++;
        end else begin
          want = expected_q.pop_front();
          check_field("hit", 32'(want.hit), 32'(res_ch.hit));
          check_field("frame", 32'(want.frame), 32'(res_ch.frame));
          check_field("replaced", 32'(want.replaced), 32'(res_ch.replaced));
          check_field("evicted_page", 32'(want.evicted_page), 32'(res_ch.evicted_page));
          check_field("hit_count", want.hit_count, res_ch.hit_count);
          check_field("miss_count", want.miss_count, res_ch.miss_count);
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) frames_cfg = cfg_ch.frames_in_use;
      if (req_ch.valid && req_ch.ready) begin
        lookup_page(req_ch.page_id, want);
        expected_q.push_back(want);
      end
      pending_n <= expected_q.size();
    end
  end

  // Stimulus build, reset and end of run.
  initial begin : run_control
    logic [PID_W-1:0] pool [24];
    logic [PID_W-1:0] pid;
    logic [PID_W-1:0] last_pid;
    int               extremes [7];
    int               rand_n;
    int               phase_n;
    int               pool_n;
    int               len;
    int               pick;
    int               gap;
    bit               bursty;
    bit               calm;
    extremes = '{16, 1, 0, 31, 2, 15, 17};
    rand_n   = 0;
    phase_n  = 0;
    last_pid = 16'h0001;

    // Zero id on an empty table, first fills, a hit and the id extremes.
    add_ref(16'h0000);
    add_ref(16'h0001);
    add_ref(16'hFFFF);
    add_ref(16'h0001);
    add_ref(16'h8000);
    add_ref(16'h5555);
    add_ref(16'hAAAA);
    // A count of zero acts as one frame; the other frames are left alone.
    add_cfg(0);
    add_ref(16'h0002);
    add_ref(16'h0003);
    add_ref(16'h0000);
    // A count above the table size clamps, and the untouched pages hit again.
    add_cfg(31);
    add_ref(16'hFFFF);
    add_ref(16'h5555);
    add_drain();
    // Three full frames: misses evict the frame with the oldest history.
    add_cfg(3);
    add_ref(16'h1234);
    add_ref(16'h0003);
    add_ref(16'h4321);
    add_ref(16'h00FF);

    // Random phases: a frame count, a working set and a pacing style each.
    while (rand_n < RANDOM_ITEMS) begin
      add_cfg(phase_n < 7 ? extremes[phase_n] : $urandom_range(0, 31));
      pool_n = $urandom_range(1, 24);
      for (int i = 0; i < pool_n; i++) pool[i] = PID_W'($urandom_range(1, 65535));
      bursty = $urandom_range(0, 2) != 0;
      len    = $urandom_range(40, 160);
      for (int j = 0; j < len && rand_n < RANDOM_ITEMS; j++) begin
        calm = rand_n >= RANDOM_ITEMS - CALM_ITEMS;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          pid = pool[$urandom_range(0, pool_n - 1)];
        end else if (pick < 80) begin
          pid = last_pid;
        end else if (pick < 88) begin
          pid = PID_W'($urandom_range(1, 65535));
        end else if (pick < 93) begin
          // The working set drifts: one page is swapped for a new one.
          pid = PID_W'($urandom_range(1, 65535));
          pool[$urandom_range(0, pool_n - 1)] = pid;
        end else if (pick < 97) begin
          pid = '0;
        end else begin
          pid = '1;
        end
        gap = (!calm && bursty && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
        add_ref(pid, gap, calm);
        if (pid != '0) begin
          last_pid = pid;
          rand_n++;
        end
        if (j == len / 2 && $urandom_range(0, 1) == 1) add_drain();
      end
      phase_n++;
    end

    // Hold the synchronous reset, then release it.
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Wait for the queue to empty and every result to arrive.
    do @(negedge clk);
    while (stim_q.size() != 0 || req_ch.valid || cfg_ch.valid || pending_n != 0);
    repeat (2 * LATENCY) @(negedge clk);
    if (expected_q.size() != 0) begin
      $error("%0d result items never arrived", expected_q.size());
      mismatch_n++;
    end
    if (mismatch_n == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin : watchdog
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
